// ===== hdl/irtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irtf_pkg: shared types and constants of the integer radix text formatter
// Format codes, sequencer states, ASCII constants and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package irtf_pkg;

    // Default value width of the formatter
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Fixed widths of the item fields
    localparam int unsigned IN_VALUE_W = 32;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned DIGIT_W    = 4;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Digit widths of the power-of-two radices, as shift amounts
    localparam logic [2:0] SHIFT_BIN = 3'd1;
    localparam logic [2:0] SHIFT_OCT = 3'd3;
    localparam logic [2:0] SHIFT_HEX = 3'd4;

    // Format codes; the two unused codes format as unsigned decimal
    typedef enum logic [OP_W-1:0] {
        OP_BIN  = 3'd0,
        OP_OCT  = 3'd1,
        OP_UDEC = 3'd2,
        OP_SDEC = 3'd3,
        OP_HEXL = 3'd4,
        OP_HEXU = 3'd5
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_SPLIT,
        S_SIGN,
        S_READ,
        S_FETCH,
        S_SHOW
    } t_state;

    // Map one digit to its ASCII code
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] digit,
                                                   input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, digit};
        if (digit < 4'd10) begin
            to_ascii = CH_ZERO + ext;
        end else if (upper) begin
            to_ascii = CH_UPPER + ext - 8'd10;
        end else begin
            to_ascii = CH_LOWER + ext - 8'd10;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/irtf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irtf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irtf_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/integer_radix_text_formatter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: accept in S_IDLE, shift each value bit into the BCD register in S_CONVERT for
// decimal items, store the digits in S_SPLIT, then emit any minus sign through S_SIGN and
// S_SHOW and each digit character through S_READ, S_FETCH and S_SHOW, where S_SHOW waits
// out any output stall.
// Throughput: one item at a time; the shared shift/add-3 unit and the single
// RAM read port set the figure. Input ready only while idle.
// Reset: synchronous active low; clears sequencer and output valid only.
// ----------------------------------------------------------------------------
// integer_radix_text_formatter: value to ASCII text in a selectable radix
// Splits the value into digits least significant first into a small RAM,
// then streams them back as ASCII, most significant first, after any minus sign, with last flag.
// ----------------------------------------------------------------------------
module integer_radix_text_formatter #(
    parameter int unsigned VALUE_WIDTH = irtf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [irtf_pkg::IN_VALUE_W-1:0]     i_value,
    input  wire logic [irtf_pkg::OP_W-1:0]           i_operation,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [irtf_pkg::CHAR_W-1:0]         o_character,
    output logic                                     o_last
);
    import irtf_pkg::*;

    // Decimal digits needed for VALUE_WIDTH bits, and derived widths
    localparam int unsigned NUM_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int unsigned RW      = NUM_DEC * DIGIT_W;
    localparam int unsigned AW      = $clog2(VALUE_WIDTH);
    localparam int unsigned CW      = $clog2(VALUE_WIDTH + 1);

    t_state                r_state, n_state;
    logic [RW-1:0]         r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [CW-1:0]         r_count, n_count;
    logic [2:0]            r_shift, n_shift;
    logic                  r_dec, n_dec;
    logic                  r_upper, n_upper;
    logic                  r_neg, n_neg;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    logic [VALUE_WIDTH+IN_VALUE_W-1:0] w_ext;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_mag;
    t_op                   w_op;
    logic                  w_neg;
    logic [RW-1:0]         w_adj;
    logic [RW-1:0]         w_next_rem;
    logic [DIGIT_W-1:0]    w_mask;
    logic [DIGIT_W-1:0]    w_digit;
    logic                  w_we;
    logic [AW-1:0]         w_raddr;
    logic [DIGIT_W-1:0]    w_rdata;

    // Take the low VALUE_WIDTH bits of the input value
    assign w_ext   = {{VALUE_WIDTH{1'b0}}, i_value};
    assign w_value = w_ext[VALUE_WIDTH-1:0];
    assign w_op    = t_op'(i_operation);
    assign w_neg   = (w_op == OP_SDEC) && w_value[VALUE_WIDTH-1];
    assign w_mag   = w_neg ? (~w_value + VALUE_WIDTH'(1)) : w_value;

    // Add 3 to every BCD digit of 5 or more before the next shift
    always_comb begin
        w_adj = r_rem;
        for (int i = 0; i < int'(NUM_DEC); i++) begin
            if (r_rem[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                w_adj[i*DIGIT_W +: DIGIT_W] = r_rem[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
    end

    // Split off the lowest digit of the remaining value
    assign w_mask     = DIGIT_W'((5'd1 << r_shift) - 5'd1);
    assign w_digit    = r_rem[DIGIT_W-1:0] & w_mask;
    assign w_next_rem = r_rem >> r_shift;
    assign w_raddr    = AW'(r_count - CW'(1));

    irtf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_digit),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_bin       = r_bin;
        n_count     = r_count;
        n_shift     = r_shift;
        n_dec       = r_dec;
        n_upper     = r_upper;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        w_we        = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_neg   = w_neg;
                    n_upper = (w_op == OP_HEXU);
                    priority if (w_op == OP_BIN) begin
                        n_shift = SHIFT_BIN;
                        n_dec   = 1'b0;
                    end else if (w_op == OP_OCT) begin
                        n_shift = SHIFT_OCT;
                        n_dec   = 1'b0;
                    end else if (w_op == OP_HEXL || w_op == OP_HEXU) begin
                        n_shift = SHIFT_HEX;
                        n_dec   = 1'b0;
                    end else begin
                        n_shift = SHIFT_HEX;
                        n_dec   = 1'b1;
                    end
                    if (n_dec) begin
                        n_rem   = '0;
                        n_bin   = w_mag;
                        n_count = CW'(VALUE_WIDTH);
                        n_state = S_CONVERT;
                    end else begin
                        n_rem   = RW'(w_mag);
                        n_count = '0;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_CONVERT: begin
                // Shift one binary bit into the BCD register
                n_rem   = {w_adj[RW-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin   = r_bin << 1;
                n_count = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                // Store one digit, least significant first
                w_we    = 1'b1;
                n_rem   = w_next_rem;
                n_count = r_count + CW'(1);
                if (w_next_rem == '0 || r_count == CW'(VALUE_WIDTH - 1)) begin
                    n_state = r_neg ? S_SIGN : S_READ;
                end
            end
            S_SIGN: begin
                n_char      = CH_MINUS;
                n_last      = 1'b0;
                n_out_valid = 1'b1;
                n_state     = S_SHOW;
            end
            S_READ: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_char      = to_ascii(w_rdata, r_upper);
                n_last      = (r_count == CW'(1));
                n_count     = r_count - CW'(1);
                n_out_valid = 1'b1;
                n_state     = S_SHOW;
            end
            S_SHOW: begin
                // Hold the item until the sink takes it
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = r_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_bin   <= n_bin;
        r_count <= n_count;
        r_shift <= n_shift;
        r_dec   <= n_dec;
        r_upper <= n_upper;
        r_neg   <= n_neg;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
`default_nettype wire

// ===== sim/integer_radix_text_formatter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_radix_text_formatter_test: self-checking bench of the radix formatter
// Feeds values in every format through a valid/ready driver with random gaps,
// predicts the ASCII text of each accepted item and checks every character
// and its last flag in order, including a long output stall.
// ----------------------------------------------------------------------------
module integer_radix_text_formatter_test;
    import irtf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned QUIET_ITEMS = 40;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned RANDOM_ITEMS = 250;

    // Format codes that the block treats as unsigned decimal
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [IN_VALUE_W-1:0] value;
        logic [OP_W-1:0]       op;
    } t_fmt_item;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [IN_VALUE_W-1:0] i_value     = '0;
    logic [OP_W-1:0]       i_operation = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [CHAR_W-1:0]     o_character;
    logic                  o_last;

    t_fmt_item   pending_items[$];
    t_text_char  expected_text[$];
    int unsigned items_total   = 0;
    int unsigned n_accepted    = 0;
    int unsigned n_chars       = 0;
    int unsigned n_errors      = 0;
    int unsigned n_cycles      = 0;
    int unsigned send_gap      = 0;
    int unsigned recv_gap      = 0;
    logic        hold_off      = 1'b0;

    integer_radix_text_formatter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Work out the text of one value and queue its characters
    function automatic void predict_text(input logic [IN_VALUE_W-1:0] value,
                                         input logic [OP_W-1:0] op);
        logic [IN_VALUE_W-1:0] mag;
        int unsigned           radix;
        logic                  upper;
        logic                  neg;
        logic [DIGIT_W-1:0]    digits[$];
        logic [CHAR_W-1:0]     code;
        t_text_char            tc;
        upper = 1'b0;
        case (op)
            OP_BIN:  radix = 2;
            OP_OCT:  radix = 8;
            OP_HEXL: radix = 16;
            OP_HEXU: begin
                radix = 16;
                upper = 1'b1;
            end
            default: radix = 10;
        endcase
        neg = (op == OP_SDEC) && value[IN_VALUE_W-1];
        mag = neg ? (~value + IN_VALUE_W'(1)) : value;
        // Split least significant digit first
        do begin
            digits.push_back(DIGIT_W'(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        if (neg) begin
            tc.ch   = CH_MINUS;
            tc.last = 1'b0;
            expected_text.push_back(tc);
        end
        for (int i = digits.size() - 1; i >= 0; i--) begin
            if (digits[i] < 4'd10) begin
                code = CH_ZERO + CHAR_W'(digits[i]);
            end else begin
                code = (upper ? CH_UPPER : CH_LOWER) + CHAR_W'(digits[i]) - 8'd10;
            end
            tc.ch   = code;
            tc.last = (i == 0);
            expected_text.push_back(tc);
        end
    endfunction

    function automatic void add_item(input logic [IN_VALUE_W-1:0] value,
                                     input logic [OP_W-1:0] op);
        t_fmt_item it;
        it.value = value;
        it.op    = op;
        pending_items.push_back(it);
        items_total++;
    endfunction

    // Driver: offer queued items, with random gaps until the quiet tail
    always @(posedge i_clk) begin
        t_fmt_item it;
        logic      quiet;
        quiet = (items_total - n_accepted) <= QUIET_ITEMS;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_text(i_value, i_operation);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap != 0 && !quiet) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap   = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else begin
                    send_gap    = 0;
                    it          = pending_items.pop_front();
                    i_in_valid  <= 1'b1;
                    i_value     <= it.value;
                    i_operation <= it.op;
                end
            end
        end
    end

    // Monitor: check each accepted character, then pick the next ready level
    always @(posedge i_clk) begin
        t_text_char tc;
        logic       rdy;
        logic       quiet;
        quiet = (items_total - n_accepted) <= QUIET_ITEMS;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_chars++;
            if (expected_text.size() == 0) begin
                $error("character: none expected, actual %h", o_character);
                n_errors++;
            end else begin
                tc = expected_text.pop_front();
                if (o_character !== tc.ch) begin
                    $error("character: expected %h, actual %h", tc.ch, o_character);
                    n_errors++;
                end
                if (o_last !== tc.last) begin
                    $error("last: expected %b, actual %b", tc.last, o_last);
                    n_errors++;
                end
            end
        end
        if (recv_gap != 0 && !quiet) begin
            recv_gap--;
            rdy = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 9);
            rdy      = 1'b0;
        end else begin
            recv_gap = 0;
            rdy      = 1'b1;
        end
        i_out_ready <= i_rst_n && rdy && !hold_off;
    end

    // Hold the output off for a long stretch so the block backs up its input
    initial begin
        while (n_accepted < 30) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Abort on a hang
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [IN_VALUE_W-1:0] v;
        logic [OP_W-1:0]       op;
        int unsigned           pick;

        // Extremes in every format, the signed corner cases and spare codes
        for (int k = 0; k < 6; k++) begin
            add_item('0, OP_W'(k));
            add_item('1, OP_W'(k));
        end
        add_item(32'h8000_0000, OP_SDEC);
        add_item(32'h8000_0000, OP_BIN);
        add_item(32'h7FFF_FFFF, OP_SDEC);
        add_item(32'h0000_0001, OP_SDEC);
        add_item(32'h8000_0001, OP_UDEC);
        add_item(32'hDEAD_BEEF, OP_HEXL);
        add_item(32'hDEAD_BEEF, OP_HEXU);
        add_item(32'h0123_ABCD, OP_OCT);
        add_item(32'd1_000_000_000, OP_UDEC);
        add_item(32'd99, OP_SPARE_6);
        add_item(32'hFFFF_FFFF, OP_SPARE_7);

        // Random values of mixed size in random formats
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            v    = $urandom;
            if (pick < 5) begin
                v = v >> $urandom_range(0, 31);
            end else if (pick == 5) begin
                v = ~(v >> $urandom_range(1, 31));
            end
            pick = $urandom_range(0, 19);
            op   = (pick < 18) ? OP_W'(pick % 6) : ((pick == 18) ? OP_SPARE_6 : OP_SPARE_7);
            add_item(v, op);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain the input side, then the expected text
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (expected_text.size() != 0) begin
            $error("last: %0d characters never arrived", expected_text.size());
            n_errors++;
        end

        $display("Formatted %0d values in all six formats plus spare codes; %0d characters",
                 n_accepted, n_chars);
        $display("checked under random gaps and a %0d-cycle output stall, %0d errors",
                 HOLD_CYCLES, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/irtf_pkg.sv
hdl/irtf_ram.sv
hdl/integer_radix_text_formatter.sv
sim/integer_radix_text_formatter_test.sv
